### rtl/core/dmc_pkg.sv
// Shared definitions for the depth-first maze carver: grid sizes, codes,
// wall masks and the neighbour bundle passed from the geometry unit.
// No dependencies.
package dmc_pkg;

  // Grid capacity
  localparam int MAX_COLS = 32;
  localparam int MAX_ROWS = 32;
  localparam int XW       = $clog2(MAX_COLS);
  localparam int YW       = $clog2(MAX_ROWS);
  localparam int CELL_W   = XW + YW;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;
  localparam int DEPTH_W  = $clog2(CELLS + 1);
  localparam int SIZE_W   = 6;
  localparam int AREA_W   = 2 * SIZE_W;

  // Cell memory word: visited mark above four wall bits
  localparam int WALL_W   = 4;
  localparam int CWORD_W  = WALL_W + 1;

  localparam logic [WALL_W-1:0] W_LEFT  = 4'b0001;
  localparam logic [WALL_W-1:0] W_RIGHT = 4'b0010;
  localparam logic [WALL_W-1:0] W_UP    = 4'b0100;
  localparam logic [WALL_W-1:0] W_DOWN  = 4'b1000;
  localparam logic [WALL_W-1:0] W_ALL   = 4'b1111;

  // Item kinds
  localparam logic [1:0] KIND_STEP    = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  // Directions
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_CARVED    = 3'd0;
  localparam logic [2:0] ST_NO_MOVE   = 3'd1;
  localparam logic [2:0] ST_BACKTRACK = 3'd2;
  localparam logic [2:0] ST_COMPLETE  = 3'd3;
  localparam logic [2:0] ST_READ      = 3'd4;
  localparam logic [2:0] ST_RESTARTED = 3'd5;

  // Register indexes
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  // Neighbours of the current cell, indexed by direction
  typedef struct packed {
    logic [3:0]             open;
    logic [3:0][XW-1:0]     nx;
    logic [3:0][YW-1:0]     ny;
    logic [3:0][CELL_W-1:0] addr;
  } nbr_t;

  function automatic logic [CELL_W-1:0] cell_of(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y);
    return CELL_W'(y) * CELL_W'(MAX_COLS) + CELL_W'(x);
  endfunction

  // Size register value: zero counts as one, excess counts as the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    if (v == '0) return SIZE_W'(1);
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Wall of the current cell that a move opens
  function automatic logic [WALL_W-1:0] here_mask(input logic [1:0] d);
    logic [WALL_W-1:0] m;
    unique case (d)
      DIR_RIGHT: m = W_RIGHT;
      DIR_LEFT:  m = W_LEFT;
      DIR_UP:    m = W_UP;
      default:   m = W_DOWN;
    endcase
    return m;
  endfunction

  // Wall of the entered cell that a move opens
  function automatic logic [WALL_W-1:0] there_mask(input logic [1:0] d);
    logic [WALL_W-1:0] m;
    unique case (d)
      DIR_RIGHT: m = W_LEFT;
      DIR_LEFT:  m = W_RIGHT;
      DIR_UP:    m = W_DOWN;
      default:   m = W_UP;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/dmc_ram.sv
// Generic synchronous RAM: one write port, one read port, registered read.
// No dependencies.
module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/dmc_geom.sv
// Neighbour geometry of the current cell: which neighbours lie inside the
// grid in use, their coordinates and cell memory addresses.
// Depends on dmc_pkg.
module dmc_geom (
  input  logic [dmc_pkg::XW-1:0]     cur_x,
  input  logic [dmc_pkg::YW-1:0]     cur_y,
  input  logic [dmc_pkg::SIZE_W-1:0] cols,
  input  logic [dmc_pkg::SIZE_W-1:0] rows,
  output dmc_pkg::nbr_t              nbr
);

  logic [dmc_pkg::SIZE_W-1:0] xe;
  logic [dmc_pkg::SIZE_W-1:0] ye;
  logic                       x_in;
  logic                       y_in;

  assign xe   = dmc_pkg::SIZE_W'(cur_x);
  assign ye   = dmc_pkg::SIZE_W'(cur_y);
  assign x_in = xe < cols;
  assign y_in = ye < rows;

  always_comb begin
    // In-grid tests per direction
    nbr.open[dmc_pkg::DIR_RIGHT] = (xe + dmc_pkg::SIZE_W'(1) < cols) && y_in;
    nbr.open[dmc_pkg::DIR_LEFT]  = (cur_x != '0) && (xe - dmc_pkg::SIZE_W'(1) < cols) && y_in;
    nbr.open[dmc_pkg::DIR_UP]    = (ye + dmc_pkg::SIZE_W'(1) < rows) && x_in;
    nbr.open[dmc_pkg::DIR_DOWN]  = (cur_y != '0) && (ye - dmc_pkg::SIZE_W'(1) < rows) && x_in;

    // Neighbour coordinates
    nbr.nx[dmc_pkg::DIR_RIGHT] = cur_x + dmc_pkg::XW'(1);
    nbr.ny[dmc_pkg::DIR_RIGHT] = cur_y;
    nbr.nx[dmc_pkg::DIR_LEFT]  = cur_x - dmc_pkg::XW'(1);
    nbr.ny[dmc_pkg::DIR_LEFT]  = cur_y;
    nbr.nx[dmc_pkg::DIR_UP]    = cur_x;
    nbr.ny[dmc_pkg::DIR_UP]    = cur_y + dmc_pkg::YW'(1);
    nbr.nx[dmc_pkg::DIR_DOWN]  = cur_x;
    nbr.ny[dmc_pkg::DIR_DOWN]  = cur_y - dmc_pkg::YW'(1);

    for (int i = 0; i < 4; i++) begin
      nbr.addr[i] = dmc_pkg::cell_of(nbr.nx[i], nbr.ny[i]);
    end
  end

endmodule

### rtl/core/dfs_maze_carver.sv
// Top level of the depth-first maze carver: sequencer, cell and stack
// memories, size registers and result register.
// Depends on dmc_pkg, dmc_ram and dmc_geom.
//
// The maze lives in two single-read-port RAMs: a cell memory (visited mark
// and four walls per cell) and a path stack. One item is worked on at a time
// and the result register lets the next item in while a result waits. For a
// step the four neighbour marks are read one after another through the cell
// memory's read port, followed by two writes for a carve, or by a stack read
// and a cell read for a backtrack (neither when only the bottom stack entry
// is left). A wall read outside the grid returns all walls without a memory
// read; a step on a finished maze or kind 3 goes straight to its result.
// After reset, after any size register write and for a restart item, the
// block sweeps both memories, one entry per cycle, and takes no item
// meanwhile; the restart result follows the sweep.
module dfs_maze_carver (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [dmc_pkg::SIZE_W-1:0] cfg_wdata,
  // input items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_kind,
  input  logic [1:0]                 in_direction,
  input  logic [dmc_pkg::XW-1:0]     in_read_x,
  input  logic [dmc_pkg::YW-1:0]     in_read_y,
  // result items
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic [dmc_pkg::XW-1:0]     out_cur_x,
  output logic [dmc_pkg::YW-1:0]     out_cur_y,
  output logic                       out_wall_left,
  output logic                       out_wall_right,
  output logic                       out_wall_up,
  output logic                       out_wall_down
);

  localparam int XW      = dmc_pkg::XW;
  localparam int YW      = dmc_pkg::YW;
  localparam int CELL_W  = dmc_pkg::CELL_W;
  localparam int DEPTH_W = dmc_pkg::DEPTH_W;
  localparam int SIZE_W  = dmc_pkg::SIZE_W;
  localparam int WALL_W  = dmc_pkg::WALL_W;
  localparam int CWORD_W = dmc_pkg::CWORD_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_WAIT     = 4'd2;
  localparam logic [3:0] S_DECIDE   = 4'd3;
  localparam logic [3:0] S_CARVE2   = 4'd4;
  localparam logic [3:0] S_POP_STK  = 4'd5;
  localparam logic [3:0] S_POP_CELL = 4'd6;
  localparam logic [3:0] S_READ     = 4'd7;
  localparam logic [3:0] S_CLEAR    = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  localparam logic [SIZE_W-1:0]  MAXC     = SIZE_W'(dmc_pkg::MAX_COLS);
  localparam logic [SIZE_W-1:0]  MAXR     = SIZE_W'(dmc_pkg::MAX_ROWS);
  localparam logic [CELL_W-1:0]  LAST_ENT = CELL_W'(dmc_pkg::CELLS - 1);
  localparam logic [DEPTH_W-1:0] FULL     = DEPTH_W'(dmc_pkg::CELLS);

  // Control registers
  logic [3:0]         state_r, state_nxt;
  logic [CELL_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               pend_r, pend_nxt;
  logic [1:0]         k_r, k_nxt;
  logic               cap_en_r, cap_en_nxt;
  logic [1:0]         cap_idx_r, cap_idx_nxt;
  logic [XW-1:0]      cur_x_r, cur_x_nxt;
  logic [YW-1:0]      cur_y_r, cur_y_nxt;
  logic [WALL_W-1:0]  cur_walls_r, cur_walls_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [DEPTH_W-1:0] count_r, count_nxt;
  logic [SIZE_W-1:0]  cols_r, cols_nxt;
  logic [SIZE_W-1:0]  rows_r, rows_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload registers
  logic [1:0]              dir_r, dir_nxt;
  logic [3:0]              vis_r;
  logic [3:0][WALL_W-1:0]  nbw_r;
  logic [2:0]              status_r, status_nxt;
  logic [WALL_W-1:0]       res_walls_r, res_walls_nxt;
  logic [2:0]              out_status_r, out_status_nxt;
  logic [XW-1:0]           out_x_r, out_x_nxt;
  logic [YW-1:0]           out_y_r, out_y_nxt;
  logic [WALL_W-1:0]       out_walls_r, out_walls_nxt;

  // Memory ports
  logic               cell_we;
  logic [CELL_W-1:0]  cell_waddr, cell_raddr;
  logic [CWORD_W-1:0] cell_wdata, cell_rdata;
  logic               stk_we;
  logic [CELL_W-1:0]  stk_waddr, stk_raddr;
  logic [CELL_W-1:0]  stk_wdata, stk_rdata;

  dmc_pkg::nbr_t              nbr;
  logic [3:0]                 avail;
  logic [CELL_W-1:0]          cur_addr;
  logic [dmc_pkg::AREA_W-1:0] area;
  logic                       accept;
  logic                       out_free;

  dmc_ram #(.WIDTH(CWORD_W), .DEPTH(dmc_pkg::CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  dmc_ram #(.WIDTH(CELL_W), .DEPTH(dmc_pkg::CELLS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  dmc_geom u_geom (
    .cur_x (cur_x_r),
    .cur_y (cur_y_r),
    .cols  (cols_r),
    .rows  (rows_r),
    .nbr   (nbr)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign avail    = nbr.open & ~vis_r;
  assign cur_addr = dmc_pkg::cell_of(cur_x_r, cur_y_r);
  assign area     = dmc_pkg::AREA_W'(cols_r) * dmc_pkg::AREA_W'(rows_r);

  // Sequencer and memory control
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    pend_nxt      = pend_r;
    k_nxt         = k_r;
    cap_en_nxt    = 1'b0;
    cap_idx_nxt   = k_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    cur_walls_nxt = cur_walls_r;
    depth_nxt     = depth_r;
    count_nxt     = count_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    dir_nxt       = dir_r;
    status_nxt    = status_r;
    res_walls_nxt = res_walls_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_walls_nxt  = out_walls_r;

    cell_we    = 1'b0;
    cell_waddr = cur_addr;
    cell_wdata = {1'b1, cur_walls_r};
    cell_raddr = nbr.addr[k_r];
    stk_we     = 1'b0;
    stk_waddr  = depth_r[CELL_W-1:0];
    stk_wdata  = nbr.addr[dir_r];
    stk_raddr  = CELL_W'(depth_r - DEPTH_W'(2));

    unique case (state_r)
      S_IDLE: begin
        cell_raddr = dmc_pkg::cell_of(in_read_x, in_read_y);
        if (accept) begin
          dir_nxt = in_direction;
          unique case (in_kind)
            dmc_pkg::KIND_STEP: begin
              if (dmc_pkg::AREA_W'(count_r) >= area) begin
                status_nxt    = dmc_pkg::ST_COMPLETE;
                res_walls_nxt = cur_walls_r;
                state_nxt     = S_EMIT;
              end else begin
                k_nxt     = 2'd0;
                state_nxt = S_SCAN;
              end
            end
            dmc_pkg::KIND_READ: begin
              status_nxt = dmc_pkg::ST_READ;
              if (SIZE_W'(in_read_x) < cols_r && SIZE_W'(in_read_y) < rows_r) begin
                state_nxt = S_READ;
              end else begin
                res_walls_nxt = dmc_pkg::W_ALL;
                state_nxt     = S_EMIT;
              end
            end
            dmc_pkg::KIND_RESTART: begin
              status_nxt    = dmc_pkg::ST_RESTARTED;
              res_walls_nxt = dmc_pkg::W_ALL;
              pend_nxt      = 1'b1;
              clr_cnt_nxt   = '0;
              cur_x_nxt     = '0;
              cur_y_nxt     = '0;
              cur_walls_nxt = dmc_pkg::W_ALL;
              depth_nxt     = DEPTH_W'(1);
              count_nxt     = DEPTH_W'(1);
              state_nxt     = S_CLEAR;
            end
            default: begin
              status_nxt    = dmc_pkg::ST_NO_MOVE;
              res_walls_nxt = cur_walls_r;
              state_nxt     = S_EMIT;
            end
          endcase
        end
      end

      // One neighbour lookup per cycle; data captured in the cycle after
      S_SCAN: begin
        cell_raddr  = nbr.addr[k_r];
        cap_en_nxt  = 1'b1;
        cap_idx_nxt = k_r;
        k_nxt       = k_r + 2'd1;
        if (k_r == 2'd3) begin
          state_nxt = S_WAIT;
        end
      end

      S_WAIT: begin
        state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        if (avail != '0) begin
          if (!avail[dir_r]) begin
            status_nxt    = dmc_pkg::ST_NO_MOVE;
            res_walls_nxt = cur_walls_r;
            state_nxt     = S_EMIT;
          end else begin
            // open the wall on this side and push the new cell
            cell_we    = 1'b1;
            cell_waddr = cur_addr;
            cell_wdata = {1'b1, cur_walls_r & ~dmc_pkg::here_mask(dir_r)};
            stk_we     = (depth_r < FULL);
            state_nxt  = S_CARVE2;
          end
        end else if (depth_r > DEPTH_W'(1)) begin
          depth_nxt = depth_r - DEPTH_W'(1);
          state_nxt = S_POP_STK;
        end else begin
          status_nxt    = dmc_pkg::ST_BACKTRACK;
          res_walls_nxt = cur_walls_r;
          state_nxt     = S_EMIT;
        end
      end

      // Enter the neighbour: open its wall and mark it visited
      S_CARVE2: begin
        cell_we       = 1'b1;
        cell_waddr    = nbr.addr[dir_r];
        cell_wdata    = {1'b1, nbw_r[dir_r] & ~dmc_pkg::there_mask(dir_r)};
        cur_x_nxt     = nbr.nx[dir_r];
        cur_y_nxt     = nbr.ny[dir_r];
        cur_walls_nxt = nbw_r[dir_r] & ~dmc_pkg::there_mask(dir_r);
        res_walls_nxt = nbw_r[dir_r] & ~dmc_pkg::there_mask(dir_r);
        count_nxt     = count_r + DEPTH_W'(1);
        if (depth_r < FULL) begin
          depth_nxt = depth_r + DEPTH_W'(1);
        end
        status_nxt = dmc_pkg::ST_CARVED;
        state_nxt  = S_EMIT;
      end

      // Stack top arrives; fetch its walls
      S_POP_STK: begin
        cur_x_nxt  = XW'(stk_rdata % dmc_pkg::MAX_COLS);
        cur_y_nxt  = YW'(stk_rdata / dmc_pkg::MAX_COLS);
        cell_raddr = stk_rdata;
        state_nxt  = S_POP_CELL;
      end

      S_POP_CELL: begin
        cur_walls_nxt = cell_rdata[WALL_W-1:0];
        res_walls_nxt = cell_rdata[WALL_W-1:0];
        status_nxt    = dmc_pkg::ST_BACKTRACK;
        state_nxt     = S_EMIT;
      end

      S_READ: begin
        res_walls_nxt = cell_rdata[WALL_W-1:0];
        state_nxt     = S_EMIT;
      end

      // Sweep: all walls set, only cell zero visited, stack zeroed
      S_CLEAR: begin
        cell_we     = 1'b1;
        cell_waddr  = clr_cnt_r;
        cell_wdata  = {(clr_cnt_r == '0), dmc_pkg::W_ALL};
        stk_we      = 1'b1;
        stk_waddr   = clr_cnt_r;
        stk_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + CELL_W'(1);
        if (clr_cnt_r == LAST_ENT) begin
          state_nxt = pend_r ? S_EMIT : S_IDLE;
          pend_nxt  = 1'b0;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_x_nxt      = cur_x_r;
          out_y_nxt      = cur_y_r;
          out_walls_nxt  = res_walls_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A size write restarts the maze
    if (cfg_we) begin
      unique case (cfg_index)
        dmc_pkg::REG_COLS: cols_nxt = dmc_pkg::clamp_size(cfg_wdata, MAXC);
        default:           rows_nxt = dmc_pkg::clamp_size(cfg_wdata, MAXR);
      endcase
      pend_nxt      = 1'b0;
      clr_cnt_nxt   = '0;
      cur_x_nxt     = '0;
      cur_y_nxt     = '0;
      cur_walls_nxt = dmc_pkg::W_ALL;
      depth_nxt     = DEPTH_W'(1);
      count_nxt     = DEPTH_W'(1);
      state_nxt     = S_CLEAR;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      k_r         <= '0;
      cap_en_r    <= 1'b0;
      cap_idx_r   <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      cur_walls_r <= dmc_pkg::W_ALL;
      depth_r     <= DEPTH_W'(1);
      count_r     <= DEPTH_W'(1);
      cols_r      <= MAXC;
      rows_r      <= MAXR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      k_r         <= k_nxt;
      cap_en_r    <= cap_en_nxt;
      cap_idx_r   <= cap_idx_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      cur_walls_r <= cur_walls_nxt;
      depth_r     <= depth_nxt;
      count_r     <= count_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload, including neighbour capture
  always_ff @(posedge clk) begin
    dir_r        <= dir_nxt;
    status_r     <= status_nxt;
    res_walls_r  <= res_walls_nxt;
    out_status_r <= out_status_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_walls_r  <= out_walls_nxt;
    if (cap_en_r) begin
      vis_r[cap_idx_r] <= cell_rdata[CWORD_W-1];
      nbw_r[cap_idx_r] <= cell_rdata[WALL_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_cur_x      = out_x_r;
  assign out_cur_y      = out_y_r;
  assign out_wall_left  = |(out_walls_r & dmc_pkg::W_LEFT);
  assign out_wall_right = |(out_walls_r & dmc_pkg::W_RIGHT);
  assign out_wall_up    = |(out_walls_r & dmc_pkg::W_UP);
  assign out_wall_down  = |(out_walls_r & dmc_pkg::W_DOWN);

endmodule

### sim/dfs_maze_carver_tb.sv
// Self-checking testbench for dfs_maze_carver: a scoreboard class predicts
// every result from its own copy of the maze, stack and grid size.
// Depends on dmc_pkg and the dfs_maze_carver RTL.
module dfs_maze_carver_tb;
  import dmc_pkg::*;

  localparam int QUIET_LIMIT  = 6000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1350;
  localparam int TAIL_CYCLES  = 30;

  // Wall bits use the W_* layout: bit 0 left, 1 right, 2 up, 3 down
  typedef struct packed {
    logic [2:0]    status;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [3:0]    walls;
  } maze_result_t;

  // Walls opened by a move, indexed by direction (right, left, up, down)
  localparam logic [3:0][3:0] NEAR_WALL = {W_DOWN, W_UP, W_LEFT, W_RIGHT};
  localparam logic [3:0][3:0] FAR_WALL  = {W_UP, W_DOWN, W_RIGHT, W_LEFT};

  class maze_scoreboard;
    logic [3:0]   wall_map [CELLS];
    bit           seen     [CELLS];
    int           trail    [CELLS];
    int           trail_len;
    int           seen_count;
    int           cur_x;
    int           cur_y;
    int           cols;
    int           rows;
    int           errors;
    maze_result_t expected_q [$];

    function new();
      cols   = MAX_COLS;
      rows   = MAX_ROWS;
      errors = 0;
      clear_maze();
    endfunction

    // Fresh maze: every wall up, only the corner cell visited and stacked
    function void clear_maze();
      for (int i = 0; i < CELLS; i++) begin
        wall_map[i] = W_ALL;
        seen[i]     = 1'b0;
        trail[i]    = 0;
      end
      seen[0]    = 1'b1;
      trail_len  = 1;
      seen_count = 1;
      cur_x      = 0;
      cur_y      = 0;
    endfunction

    // Size writes saturate at both ends and always rebuild the maze
    function void set_size(logic idx, logic [SIZE_W-1:0] v);
      int n;
      int top;
      top = (idx == REG_COLS) ? MAX_COLS : MAX_ROWS;
      n   = (v == 0) ? 1 : ((int'(v) > top) ? top : int'(v));
      if (idx == REG_COLS) cols = n;
      else rows = n;
      clear_maze();
    endfunction

    function void neighbour(logic [1:0] d, output int nx, output int ny);
      nx = cur_x;
      ny = cur_y;
      case (d)
        DIR_RIGHT: nx = cur_x + 1;
        DIR_LEFT:  nx = cur_x - 1;
        DIR_UP:    ny = cur_y + 1;
        default:   ny = cur_y - 1;
      endcase
    endfunction

    // Unvisited in-grid neighbours of the current cell, one bit per direction
    function logic [3:0] free_dirs();
      logic [3:0] m;
      int nx;
      int ny;
      for (int d = 0; d < 4; d++) begin
        neighbour(d[1:0], nx, ny);
        m[d] = nx >= 0 && nx < cols && ny >= 0 && ny < rows && !seen[ny * MAX_COLS + nx];
      end
      return m;
    endfunction

    function logic [2:0] carve_step(logic [1:0] d);
      logic [3:0] m;
      int nx;
      int ny;
      int here;
      int there;
      if (seen_count >= cols * rows) return ST_COMPLETE;
      m = free_dirs();
      if (m != 4'b0000) begin
        if (!m[d]) return ST_NO_MOVE;
        neighbour(d, nx, ny);
        here  = cur_y * MAX_COLS + cur_x;
        there = ny * MAX_COLS + nx;
        wall_map[here]  = wall_map[here] & ~NEAR_WALL[d];
        wall_map[there] = wall_map[there] & ~FAR_WALL[d];
        seen[there] = 1'b1;
        seen_count++;
        if (trail_len < CELLS) begin
          trail[trail_len] = there;
          trail_len++;
        end
        cur_x = nx;
        cur_y = ny;
        return ST_CARVED;
      end
      // dead end: fall back to the previous cell on the path, if any
      if (trail_len > 1) begin
        trail_len--;
        cur_x = trail[trail_len - 1] % MAX_COLS;
        cur_y = trail[trail_len - 1] / MAX_COLS;
      end
      return ST_BACKTRACK;
    endfunction

    // Accepted input item: advance the maze and queue the result it causes
    function void note_item(logic [1:0] kind, logic [1:0] dir,
                            logic [XW-1:0] rx, logic [YW-1:0] ry);
      maze_result_t r;
      logic [3:0]   shown;
      case (kind)
        KIND_STEP:    r.status = carve_step(dir);
        KIND_READ:    r.status = ST_READ;
        KIND_RESTART: begin
          clear_maze();
          r.status = ST_RESTARTED;
        end
        default:      r.status = ST_NO_MOVE;
      endcase
      shown = wall_map[cur_y * MAX_COLS + cur_x];
      if (kind == KIND_READ)
        shown = (rx < cols && ry < rows) ? wall_map[ry * MAX_COLS + rx] : W_ALL;
      r.x     = XW'(cur_x);
      r.y     = YW'(cur_y);
      r.walls = shown;
      expected_q = {expected_q, r};
    endfunction

    function void match(string what, logic [4:0] want, logic [4:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(maze_result_t got);
      maze_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d at (%0d,%0d)",
                 $time, got.status, got.x, got.y);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      match("status", want.status, got.status);
      match("cur_x", want.x, got.x);
      match("cur_y", want.y, got.y);
      match("wall_left", want.walls[0], got.walls[0]);
      match("wall_right", want.walls[1], got.walls[1]);
      match("wall_up", want.walls[2], got.walls[2]);
      match("wall_down", want.walls[3], got.walls[3]);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              cfg_we       = 1'b0;
  logic              cfg_index    = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata    = '0;
  logic              in_valid     = 1'b0;
  logic [1:0]        in_kind      = KIND_STEP;
  logic [1:0]        in_direction = DIR_RIGHT;
  logic [XW-1:0]     in_read_x    = '0;
  logic [YW-1:0]     in_read_y    = '0;
  logic              out_stall    = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [XW-1:0]     out_cur_x;
  logic [YW-1:0]     out_cur_y;
  logic              out_wall_left;
  logic              out_wall_right;
  logic              out_wall_up;
  logic              out_wall_down;

  int             idle_pct    = 36;
  bit             squeeze_req = 1'b0;
  int             quiet       = 0;
  maze_scoreboard sb          = new();

  dfs_maze_carver i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_direction   (in_direction),
    .in_read_x      (in_read_x),
    .in_read_y      (in_read_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_cur_x      (out_cur_x),
    .out_cur_y      (out_cur_y),
    .out_wall_left  (out_wall_left),
    .out_wall_right (out_wall_right),
    .out_wall_up    (out_wall_up),
    .out_wall_down  (out_wall_down)
  );

  always #1 clk = ~clk;

  // Offer one item, with a random gap first, and hold it until taken
  task automatic push_item(input logic [1:0] kind, input logic [1:0] dir,
                           input logic [XW-1:0] rx, input logic [YW-1:0] ry);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_direction <= dir;
    in_read_x    <= rx;
    in_read_y    <= ry;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(kind, dir, rx, ry);
  endtask

  task automatic step(input logic [1:0] dir);
    push_item(KIND_STEP, dir, XW'($urandom_range(31)), YW'($urandom_range(31)));
  endtask

  task automatic probe(input int x, input int y);
    push_item(KIND_READ, 2'($urandom_range(3)), XW'(x), YW'(y));
  endtask

  // Stop offering and wait until every queued result has come back
  task automatic finish_phase();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_size(idx, v);
  endtask

  // Both sizes; a read in between lets the first clearing sweep finish
  task automatic set_grid(input int c, input int r);
    write_reg(REG_COLS, SIZE_W'(c));
    probe($urandom_range(31), $urandom_range(31));
    finish_phase();
    write_reg(REG_ROWS, SIZE_W'(r));
  endtask

  // Mostly small grids so mazes finish; extremes now and then
  function automatic int pick_size();
    int extremes [7] = '{0, 1, 2, 31, 32, 33, 63};
    if ($urandom_range(99) < 25) return extremes[$urandom_range(6)];
    return $urandom_range(1, 6);
  endfunction

  // Usually head for an unvisited neighbour so the carve gets somewhere
  function automatic logic [1:0] choose_dir();
    logic [3:0] m;
    logic [1:0] d;
    m = sb.free_dirs();
    d = 2'($urandom_range(3));
    if (m != 4'b0000 && $urandom_range(99) < 70)
      while (!m[d]) d = 2'($urandom_range(3));
    return d;
  endfunction

  // Item source
  initial begin : item_source
    int issued;
    int phase;
    int pick;
    int n;
    issued = 0;
    phase  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // corners of the full grid, moves blocked and taken, spare kind, restart
    probe(0, 0);
    probe(31, 31);
    probe(31, 0);
    probe(0, 31);
    step(DIR_LEFT);
    step(DIR_DOWN);
    step(DIR_RIGHT);
    step(DIR_UP);
    step(DIR_LEFT);
    step(DIR_DOWN);
    probe(1, 1);
    push_item(KIND_SPARE, DIR_UP, 5'd31, 5'd31);
    push_item(KIND_RESTART, DIR_DOWN, 5'd0, 5'd0);
    probe(1, 1);
    finish_phase();

    // zero sizes count as one: a single-cell maze is finished from the start
    set_grid(0, 0);
    step(DIR_RIGHT);
    probe(1, 0);
    probe(0, 1);
    probe(0, 0);
    finish_phase();

    // oversized columns saturate: one long corridor
    set_grid(63, 1);
    step(DIR_RIGHT);
    step(DIR_RIGHT);
    step(DIR_LEFT);
    probe(31, 0);
    probe(0, 1);
    finish_phase();

    // random phases, each on a fresh grid size
    while (issued < RANDOM_ITEMS) begin
      set_grid(pick_size(), pick_size());
      idle_pct = (phase == 2) ? 0 : 36;
      if (phase == 1) squeeze_req <= 1'b1;
      n = $urandom_range(40, 140);
      repeat (n) begin
        pick = $urandom_range(99);
        if (pick < 78) step(choose_dir());
        else if (pick < 92) begin
          if ($urandom_range(1) == 1)
            probe($urandom_range(sb.cols - 1), $urandom_range(sb.rows - 1));
          else
            probe($urandom_range(31), $urandom_range(31));
        end else if (pick < 95)
          push_item(KIND_RESTART, 2'($urandom_range(3)), XW'($urandom_range(31)),
                    YW'($urandom_range(31)));
        else
          push_item(KIND_SPARE, 2'($urandom_range(3)), XW'($urandom_range(31)),
                    YW'($urandom_range(31)));
        issued++;
      end
      finish_phase();
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("dfs_maze_carver_tb: clean");
    end else begin
      $display("dfs_maze_carver_tb: errors");
    end
    $finish;
  end

  // Result sink: random stalls, plus one long hold-off to back the block up
  initial begin : result_sink
    maze_result_t got;
    int           hold;
    bit           squeezed;
    hold     = 0;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        got.status = out_status;
        got.x      = out_cur_x;
        got.y      = out_cur_y;
        got.walls  = {out_wall_down, out_wall_up, out_wall_right, out_wall_left};
        sb.check_result(got);
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (squeeze_req && !squeezed) begin
        squeezed  = 1'b1;
        hold      = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("dfs_maze_carver_tb: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
